### rtl/tmprc_pkg.sv
// ----------------------------------------------------------------------------
// tmprc_pkg
// Shared types, codes and constants of the timed motor pulse controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tmprc_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int MS_W          = 16;
    localparam int DUTY_W        = 16;
    localparam int DUR_W         = 16;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_START_PE = 2'd1,
        OP_START_NP = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_STOP  = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DRIVE = 2'd1,
        PH_COOL  = 2'd2
    } phase_t;

    // One accepted request or tick.
    typedef struct packed {
        op_t              op;
        logic [MS_W-1:0]  elapsed_ms;
        logic [DUTY_W-1:0] duty;
        logic             dir_req;
        logic [DUR_W-1:0] drive_time;
        logic [DUR_W-1:0] cool_time;
    } item_t;

    // Controller state apart from the timer, whose width is a parameter.
    typedef struct packed {
        phase_t           phase;
        logic             pending;
        logic [DUTY_W-1:0] held_duty;
        logic             held_dir;
        logic [DUR_W-1:0] held_drive_time;
        logic [DUR_W-1:0] held_cool_time;
    } ctl_t;

    typedef struct packed {
        event_t           drive_event;
        logic [DUTY_W-1:0] drive_duty;
        logic             drive_dir;
        phase_t           phase_now;
    } result_t;

endpackage

`default_nettype wire

### rtl/tmprc_step.sv
// ----------------------------------------------------------------------------
// tmprc_step
// Next-state and result logic for one tick or start request.
// ----------------------------------------------------------------------------
`default_nettype none

module tmprc_step #(
    parameter int TIME_BITS = tmprc_pkg::TIME_BITS_DEF
) (
    input  tmprc_pkg::item_t      item,
    input  tmprc_pkg::ctl_t       ctl,
    input  logic [TIME_BITS-1:0]  timer,
    output tmprc_pkg::ctl_t       ctl_next,
    output logic [TIME_BITS-1:0]  timer_next,
    output tmprc_pkg::result_t    result
);
    import tmprc_pkg::*;

    localparam int SUM_W = ((TIME_BITS > MS_W) ? TIME_BITS :
                            ((TIME_BITS > DUR_W) ? TIME_BITS : MS_W)) + 1;

    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     tmax;
    logic [TIME_BITS-1:0] timer_add;
    logic                 drive_done;
    logic                 cool_done;
    phase_t               phase_cur;

    // Saturating add of the elapsed milliseconds.
    assign sum       = SUM_W'(timer) + SUM_W'(item.elapsed_ms);
    assign tmax      = SUM_W'({TIME_BITS{1'b1}});
    assign timer_add = (sum > tmax) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

    assign drive_done = SUM_W'(timer_add) >= SUM_W'(ctl.held_drive_time);
    assign cool_done  = SUM_W'(timer_add) >= SUM_W'(ctl.held_cool_time);

    always_comb begin
        ctl_next           = ctl;
        timer_next         = timer;
        result.drive_event = EV_NONE;
        result.drive_duty  = '0;
        result.drive_dir   = 1'b0;

        // The unused phase code behaves as idle.
        case (ctl.phase)
            PH_DRIVE: phase_cur = PH_DRIVE;
            PH_COOL:  phase_cur = PH_COOL;
            default:  phase_cur = PH_IDLE;
        endcase
        ctl_next.phase = phase_cur;

        case (item.op)
            OP_TICK: begin
                case (phase_cur)
                    PH_DRIVE: begin
                        timer_next = timer_add;
                        if (drive_done) begin
                            result.drive_event = EV_STOP;
                            ctl_next.phase     = PH_COOL;
                            timer_next         = '0;
                        end
                    end
                    PH_COOL: begin
                        timer_next = timer_add;
                        if (cool_done) begin
                            ctl_next.phase = PH_IDLE;
                            timer_next     = '0;
                        end
                    end
                    default: begin
                        if (ctl.pending) begin
                            result.drive_event = EV_START;
                            result.drive_duty  = ctl.held_duty;
                            result.drive_dir   = ctl.held_dir;
                            ctl_next.phase     = PH_DRIVE;
                            ctl_next.pending   = 1'b0;
                            timer_next         = '0;
                        end
                    end
                endcase
            end
            OP_START_PE, OP_START_NP: begin
                if (phase_cur == PH_IDLE) begin
                    ctl_next.pending         = 1'b1;
                    ctl_next.held_duty       = item.duty;
                    ctl_next.held_dir        = item.dir_req;
                    ctl_next.held_drive_time = item.drive_time;
                    ctl_next.held_cool_time  = item.cool_time;
                    timer_next               = '0;
                end else if (phase_cur == PH_DRIVE && item.op == OP_START_PE) begin
                    ctl_next.held_duty       = item.duty;
                    ctl_next.held_dir        = item.dir_req;
                    ctl_next.held_drive_time = item.drive_time;
                    ctl_next.held_cool_time  = item.cool_time;
                    timer_next               = '0;
                    if (item.dir_req == ctl.held_dir) begin
                        result.drive_event = EV_START;
                        result.drive_duty  = item.duty;
                        result.drive_dir   = item.dir_req;
                    end else begin
                        // Reversal: stop now, cool down, then run the new request.
                        result.drive_event = EV_STOP;
                        ctl_next.phase     = PH_COOL;
                        ctl_next.pending   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        result.phase_now = ctl_next.phase;
    end

endmodule

`default_nettype wire

### rtl/timed_motor_pulse_reversal_cooldown_core.sv
// ----------------------------------------------------------------------------
// timed_motor_pulse_reversal_cooldown_core
// Timed DC motor pulse controller with idle, driving and cooldown phases.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata (low bit up)                                  | tuser
//  --------+-----+-----------------------------------------------------+-----------
//  s_      | in  | elapsed_ms, duty, dir_req, drive_time, cool_time    | operation
//  m_      | out | drive_duty, drive_dir, phase_now                    | drive_event
//
//  Every input transfer produces exactly one result transfer.
//  An accepted item waits in the input register, is evaluated against the
//  controller state, and lands in the output register; one item per cycle is
//  sustained while m_tready stays high. m_tvalid rises once the item has
//  moved from the input register into the output register.
//  While a result waits on m_tready, an empty input register still takes one
//  item; once both registers hold items, s_tready follows m_tready, so a
//  stalled output then stalls the input as well.
//  aresetn is synchronous and active low; it returns the controller to idle
//  with a cleared timer and no queued request, and empties both registers.
//
`default_nettype none

module timed_motor_pulse_reversal_cooldown_core #(
    parameter int TIME_BITS = tmprc_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // elapsed_ms[15:0], duty[31:16], dir_req[32], drive_time[48:33],
    // cool_time[64:49], zero fill [71:65]
    input  logic [tmprc_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [tmprc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // drive_duty[15:0], drive_dir[16], phase_now[18:17], zero fill [23:19]
    output logic [tmprc_pkg::M_TDATA_W-1:0] m_tdata,
    // drive_event[1:0]
    output logic [tmprc_pkg::M_TUSER_W-1:0] m_tuser
);
    import tmprc_pkg::*;

    // Input register.
    logic                 in_valid_reg;
    item_t                in_item_reg;
    // Controller state.
    ctl_t                 ctl_reg;
    ctl_t                 ctl_next;
    logic [TIME_BITS-1:0] timer_reg;
    logic [TIME_BITS-1:0] timer_next;
    // Output register.
    logic                 out_valid_reg;
    result_t              out_res_reg;
    result_t              res_next;

    logic                 advance;
    item_t                s_item;

    // The input item moves on whenever the output register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign s_item.op         = op_t'(s_tuser[1:0]);
    assign s_item.elapsed_ms = s_tdata[15:0];
    assign s_item.duty       = s_tdata[31:16];
    assign s_item.dir_req    = s_tdata[32];
    assign s_item.drive_time = s_tdata[48:33];
    assign s_item.cool_time  = s_tdata[64:49];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload needs no reset; it is qualified by in_valid_reg.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_item;
        end
    end

    tmprc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .item       (in_item_reg),
        .ctl        (ctl_reg),
        .timer      (timer_reg),
        .ctl_next   (ctl_next),
        .timer_next (timer_next),
        .result     (res_next)
    );

    // State follows each evaluated item, in order, one per cycle while the output register is free or drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.phase           <= PH_IDLE;
            ctl_reg.pending         <= 1'b0;
            ctl_reg.held_duty       <= '0;
            ctl_reg.held_dir        <= 1'b0;
            ctl_reg.held_drive_time <= '0;
            ctl_reg.held_cool_time  <= '0;
            timer_reg               <= '0;
        end else if (advance) begin
            ctl_reg   <= ctl_next;
            timer_reg <= timer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.drive_event;
    assign m_tdata  = {5'b0, out_res_reg.phase_now, out_res_reg.drive_dir,
                       out_res_reg.drive_duty};

    // A drive start always leaves the motor in the driving phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_START) |-> (out_res_reg.phase_now == PH_DRIVE))
        else $error("drive start reported outside the driving phase");

    // A drive stop always leads into cooldown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_STOP) |-> (out_res_reg.phase_now == PH_COOL))
        else $error("drive stop reported without entering cooldown");

    // Duty and direction are only shown with a drive start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != EV_START) |->
        (out_res_reg.drive_duty == '0 && !out_res_reg.drive_dir))
        else $error("duty or direction shown without a drive start");

    // A queued request never coexists with an active drive.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.pending |-> (ctl_reg.phase != PH_DRIVE))
        else $error("request queued while driving");

    // Back-pressure on the input only arises from a held item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked output");

endmodule

`default_nettype wire

### bench/motor_pulse_scoreboard.sv
// ----------------------------------------------------------------------------
// motor_pulse_scoreboard
// Watches both stream channels of the motor pulse controller, predicts each
// result from the accepted requests and ticks, and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_pulse_scoreboard (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // elapsed_ms[15:0], duty[31:16], dir_req[32], drive_time[48:33],
    // cool_time[64:49], zero fill [71:65]
    input  logic [tmprc_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [tmprc_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // drive_duty[15:0], drive_dir[16], phase_now[18:17], zero fill [23:19]
    input  logic [tmprc_pkg::M_TDATA_W-1:0] m_tdata,
    // drive_event[1:0]
    input  logic [tmprc_pkg::M_TUSER_W-1:0] m_tuser,
    output int                              mismatches,
    output int                              results_owed
);

    import tmprc_pkg::*;

    localparam int TB = TIME_BITS_DEF;

    // Predicted controller state.
    phase_t        ph;
    logic [TB-1:0] run_timer;
    logic          queued;
    item_t         held;

    result_t       expected_drive[$];

    // Advances the predicted controller by one item and returns its result.
    function automatic result_t step_controller(item_t it);
        result_t     r;
        logic [TB:0] sum;
        r.drive_event = EV_NONE;
        r.drive_duty  = '0;
        r.drive_dir   = 1'b0;
        if (ph != PH_DRIVE && ph != PH_COOL) begin
            ph = PH_IDLE;
        end
        sum = {1'b0, run_timer} + (TB+1)'(it.elapsed_ms);
        case (it.op)
            OP_TICK: begin
                if (ph == PH_IDLE) begin
                    if (queued) begin
                        r.drive_event = EV_START;
                        r.drive_duty  = held.duty;
                        r.drive_dir   = held.dir_req;
                        ph            = PH_DRIVE;
                        run_timer     = '0;
                        queued        = 1'b0;
                    end
                end else begin
                    run_timer = sum[TB] ? '1 : sum[TB-1:0];
                    if (ph == PH_DRIVE) begin
                        if (run_timer >= held.drive_time) begin
                            r.drive_event = EV_STOP;
                            ph            = PH_COOL;
                            run_timer     = '0;
                        end
                    end else if (run_timer >= held.cool_time) begin
                        ph        = PH_IDLE;
                        run_timer = '0;
                    end
                end
            end
            OP_START_PE, OP_START_NP: begin
                if (ph == PH_IDLE) begin
                    queued    = 1'b1;
                    run_timer = '0;
                    held      = it;
                end else if (ph == PH_DRIVE && it.op == OP_START_PE) begin
                    if (it.dir_req == held.dir_req) begin
                        // Same direction: refresh and re-apply the drive.
                        held          = it;
                        run_timer     = '0;
                        r.drive_event = EV_START;
                        r.drive_duty  = it.duty;
                        r.drive_dir   = it.dir_req;
                    end else begin
                        // Reversal: stop now, cool down, keep the request.
                        r.drive_event = EV_STOP;
                        ph            = PH_COOL;
                        run_timer     = '0;
                        queued        = 1'b1;
                        held          = it;
                    end
                end
            end
            default: begin
            end
        endcase
        r.phase_now = ph;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        item_t   it;
        if (!aresetn) begin
            ph        = PH_IDLE;
            run_timer = '0;
            queued    = 1'b0;
            held      = '0;
            expected_drive.delete();
        end else begin
            // Results first, so a result never pairs with an item accepted
            // at the same edge.
            if (m_tvalid && m_tready) begin
                got.drive_event = event_t'(m_tuser);
                got.drive_duty  = m_tdata[15:0];
                got.drive_dir   = m_tdata[16];
                got.phase_now   = phase_t'(m_tdata[18:17]);
                if (expected_drive.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transfer, got event=%0d duty=%h",
                             $time, got.drive_event, got.drive_duty,
                             " dir=%0d phase=%0d", got.drive_dir, got.phase_now);
                end else begin
                    want = expected_drive.pop_front();
                    if (got !== want || m_tdata[23:19] !== '0) begin
                        mismatches++;
                        $display("%0t: mismatch, expected event=%0d duty=%h dir=%0d",
                                 $time, want.drive_event, want.drive_duty,
                                 want.drive_dir,
                                 " phase=%0d fill=00, got event=%0d duty=%h",
                                 want.phase_now, got.drive_event, got.drive_duty,
                                 " dir=%0d phase=%0d fill=%h",
                                 got.drive_dir, got.phase_now, m_tdata[23:19]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                it.op         = op_t'(s_tuser);
                it.elapsed_ms = s_tdata[15:0];
                it.duty       = s_tdata[31:16];
                it.dir_req    = s_tdata[32];
                it.drive_time = s_tdata[48:33];
                it.cool_time  = s_tdata[64:49];
                expected_drive.push_back(step_controller(it));
            end
        end
        results_owed = expected_drive.size();
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench of the timed motor pulse controller: a directed walk
// through every phase and corner, then random traffic with random idling on
// both channels and one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import tmprc_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // elapsed_ms[15:0], duty[31:16], dir_req[32], drive_time[48:33],
    // cool_time[64:49], zero fill [71:65]
    logic [S_TDATA_W-1:0]  s_tdata;
    // operation[1:0]
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // drive_duty[15:0], drive_dir[16], phase_now[18:17], zero fill [23:19]
    logic [M_TDATA_W-1:0]  m_tdata;
    // drive_event[1:0]
    logic [M_TUSER_W-1:0]  m_tuser;

    int mismatches;
    int results_owed;

    // Idle percentages of the sender and the receiver. The stimulus process
    // changes them between phases; the receiver process only reads them.
    int tx_idle_pct;
    int rx_idle_pct;

    // Each increment asks the receiver process for one long hold-off.
    int hold_requests;

    always #4 aclk = ~aclk;

    timed_motor_pulse_reversal_cooldown_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    motor_pulse_scoreboard scoreboard (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    // Offers one item on the input channel and returns at the rising edge
    // where it was accepted. The valid is left high on return so that a
    // back-to-back item never lowers and raises it in the same time step;
    // a gap, if any, lowers it at the next falling edge instead.
    task automatic offer(input op_t op, input logic [15:0] ms, input logic [15:0] duty,
                         input logic dir, input logic [15:0] drive_ms,
                         input logic [15:0] cool_ms);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, cool_ms, drive_ms, dir, duty, ms};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // One random item. Ticks dominate and durations are mostly short, so the
    // controller keeps cycling through driving and cooldown; a minority of
    // full-range values covers every field bit and timer saturation.
    task automatic offer_random();
        int          pick;
        op_t         op;
        logic [15:0] ms;
        logic [15:0] drive_ms;
        logic [15:0] cool_ms;
        pick = $urandom_range(99);
        if (pick < 55)
            op = OP_TICK;
        else if (pick < 75)
            op = OP_START_PE;
        else if (pick < 94)
            op = OP_START_NP;
        else
            op = OP_UNUSED;
        ms       = ($urandom_range(99) < 80) ? 16'($urandom_range(12)) : 16'($urandom);
        drive_ms = ($urandom_range(99) < 85) ? 16'($urandom_range(30)) : 16'($urandom);
        cool_ms  = ($urandom_range(99) < 85) ? 16'($urandom_range(30)) : 16'($urandom);
        offer(op, ms, 16'($urandom), 1'($urandom), drive_ms, cool_ms);
    endtask

    // Receiver: random ready at each falling edge, except during a requested
    // hold-off, which this process counts out on its own while the sender
    // keeps offering items and the block backs up into its input.
    initial begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        tx_idle_pct   = 22;
        rx_idle_pct   = 45;
        hold_requests = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_TICK;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed walk. Idle: a tick with nothing queued and the unused
        // operation both do nothing.
        offer(OP_TICK,     16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_UNUSED,   16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        // A second start in idle overwrites the first; zero durations still
        // last until the next tick.
        offer(OP_START_NP, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF);
        offer(OP_START_NP, 16'hFFFF, 16'h1234, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        // Both kinds of start are ignored during cooldown.
        offer(OP_START_PE, 16'h0000, 16'hBEEF, 1'b1, 16'h0005, 16'h0005);
        offer(OP_START_NP, 16'h0000, 16'hBEEF, 1'b0, 16'h0005, 16'h0005);
        offer(OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        // Longest drive: the timer saturates and only then meets the limit.
        offer(OP_START_PE, 16'h0000, 16'hFFFF, 1'b1, 16'hFFFF, 16'h0003);
        offer(OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'd40000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'd40000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'h0001, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        // While driving: a non-preemptive start and the unused operation are
        // ignored, a same-direction preemptive start refreshes the drive and
        // an opposite one stops it and queues the reversal.
        offer(OP_START_PE, 16'h0000, 16'hAAAA, 1'b0, 16'd100, 16'd5);
        offer(OP_TICK,     16'd3,    16'h0000, 1'b1, 16'h0000, 16'h0000);
        offer(OP_START_NP, 16'h0000, 16'h0F0F, 1'b1, 16'd1, 16'd1);
        offer(OP_START_PE, 16'h0000, 16'h5555, 1'b0, 16'd10, 16'd9);
        offer(OP_UNUSED,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_START_PE, 16'h0000, 16'h00FF, 1'b1, 16'd7, 16'd2);
        offer(OP_TICK,     16'd2,    16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'd0,    16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'd7,    16'h0000, 1'b0, 16'h0000, 16'h0000);
        offer(OP_TICK,     16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000);

        // Random traffic in three thirds: a slow sender with a slower
        // receiver, then the reverse, then both at full rate with one long
        // result hold-off to back the block up.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 45;
                rx_idle_pct = 22;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_requests++;
            end
            offer_random();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain: every expected result must arrive, then a further wait
        // catches any stray transfer.
        wait (results_owed == 0);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("PASS timed_motor_pulse_reversal_cooldown_core");
        end else begin
            $display("FAIL timed_motor_pulse_reversal_cooldown_core");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL timed_motor_pulse_reversal_cooldown_core");
        $finish;
    end

endmodule

### sim.f
rtl/tmprc_pkg.sv
rtl/tmprc_step.sv
rtl/timed_motor_pulse_reversal_cooldown_core.sv
bench/motor_pulse_scoreboard.sv
bench/tb.sv
